[src/hhfs_pkg.sv]
// ----------------------------------------------------------------------------
// hhfs_pkg
// Shared types and constants of the HTTP header field splitter.
// ----------------------------------------------------------------------------
package hhfs_pkg;

  localparam int unsigned NAME_MAX = 32;
  localparam int unsigned LEN_W    = $clog2(NAME_MAX + 1);
  localparam int unsigned NAME_AW  = (NAME_MAX > 1) ? $clog2(NAME_MAX) : 1;
  localparam int unsigned TOTAL_W  = 16;

  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;

  localparam logic [TOTAL_W-1:0] TOTAL_MAX = '1;

  typedef enum logic [1:0] {
    KIND_NAME  = 2'd0,
    KIND_VALUE = 2'd1,
    KIND_END   = 2'd2,
    KIND_DONE  = 2'd3
  } kind_e;

  // controller -> datapath
  typedef struct packed {
    logic  take;      // latch the input beat
    logic  apply;     // commit the state update of the latched byte
    logic  rd_load;   // read the name store at the flush index
    logic  rd_adv;    // step the flush index
    logic  out_load;  // load the output register
    kind_e out_kind;
    logic  out_run_last;
    logic  buf_clear; // end of buffer: drop line state and count
  } ctl_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic emit_end;
    logic emit_value;
    logic flush;
    logic flush_last;
    logic last;
    logic in_value;
    logic out_free;
  } dp_stat_t;

endpackage

[src/hhfs_dp.sv]
// ----------------------------------------------------------------------------
// hhfs_dp
// Datapath: input latch, line state, name store, header count, output register.
// ----------------------------------------------------------------------------
module hhfs_dp import hhfs_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  ctl_cmd_t           cmd_i,
  output dp_stat_t           stat_o,
  input  logic [7:0]         byte_in_i,
  input  logic               last_byte_i,
  input  logic               out_stall_i,
  output logic               out_valid_o,
  output logic [1:0]         kind_o,
  output logic [7:0]         data_byte_o,
  output logic [TOTAL_W-1:0] header_total_o,
  output logic               run_last_o
);

  logic [7:0]         byte_q;
  logic               last_q;
  logic [7:0]         name_store [NAME_MAX];
  logic [7:0]         rd_data_q;
  logic [LEN_W-1:0]   pos_q, trim_q, rd_idx_q;
  logic [LEN_W-1:0]   pos_next;
  logic               in_value_q, begun_q, after_cr_q;
  logic [TOTAL_W-1:0] count_q;
  logic               out_valid_q;
  logic [1:0]         kind_q;
  logic [7:0]         data_q;
  logic [TOTAL_W-1:0] total_q;
  logic               run_last_q;

  logic swallow, eol, normal, blank, colon_hdr, name_byte, pos_room;

  assign swallow   = after_cr_q && (byte_q == CH_LF);
  assign eol       = !swallow && ((byte_q == CH_CR) || (byte_q == CH_LF));
  assign normal    = !swallow && !eol;
  assign blank     = (byte_q == CH_SPACE) || (byte_q == CH_TAB);
  assign colon_hdr = normal && !in_value_q && (byte_q == CH_COLON);
  assign name_byte = normal && !in_value_q && (byte_q != CH_COLON);
  assign pos_room  = pos_q < LEN_W'(NAME_MAX);
  assign pos_next  = pos_room ? pos_q + LEN_W'(1) : pos_q;

  always_comb begin
    stat_o.emit_end   = eol && in_value_q;
    stat_o.emit_value = normal && in_value_q && (begun_q || !blank);
    stat_o.flush      = colon_hdr && (trim_q != '0);
    stat_o.flush_last = (rd_idx_q + LEN_W'(1)) == trim_q;
    stat_o.last       = last_q;
    stat_o.in_value   = in_value_q;
    stat_o.out_free   = !out_valid_q || !out_stall_i;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.take) begin
      byte_q <= byte_in_i;
      last_q <= last_byte_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.apply && name_byte && pos_room) begin
      name_store[pos_q[NAME_AW-1:0]] <= byte_q;
    end
    if (cmd_i.rd_load) begin
      rd_data_q <= name_store[rd_idx_q[NAME_AW-1:0]];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q      <= '0;
      trim_q     <= '0;
      in_value_q <= 1'b0;
      begun_q    <= 1'b0;
      after_cr_q <= 1'b0;
      count_q    <= '0;
      rd_idx_q   <= '0;
    end else if (cmd_i.buf_clear) begin
      pos_q      <= '0;
      trim_q     <= '0;
      in_value_q <= 1'b0;
      begun_q    <= 1'b0;
      after_cr_q <= 1'b0;
      count_q    <= '0;
    end else if (cmd_i.apply) begin
      if (swallow) begin
        after_cr_q <= 1'b0;
      end else if (eol) begin
        pos_q      <= '0;
        trim_q     <= '0;
        in_value_q <= 1'b0;
        begun_q    <= 1'b0;
        after_cr_q <= (byte_q == CH_CR);
      end else begin
        after_cr_q <= 1'b0;
        if (in_value_q) begin
          if (!blank) begin
            begun_q <= 1'b1;
          end
        end else if (colon_hdr) begin
          if (count_q != TOTAL_MAX) begin
            count_q <= count_q + TOTAL_W'(1);
          end
          in_value_q <= 1'b1;
          begun_q    <= 1'b0;
          rd_idx_q   <= '0;
        end else begin
          pos_q <= pos_next;
          if (!blank) begin
            trim_q <= pos_next;
          end
        end
      end
    end else if (cmd_i.rd_adv) begin
      rd_idx_q <= rd_idx_q + LEN_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      kind_q     <= cmd_i.out_kind;
      run_last_q <= cmd_i.out_run_last;
      case (cmd_i.out_kind)
        KIND_NAME:  data_q <= rd_data_q;
        KIND_VALUE: data_q <= byte_q;
        default:    data_q <= '0;
      endcase
      total_q <= (cmd_i.out_kind == KIND_DONE) ? count_q : '0;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign kind_o         = kind_q;
  assign data_byte_o    = data_q;
  assign header_total_o = total_q;
  assign run_last_o     = run_last_q;

endmodule

[src/hhfs_ctrl.sv]
// ----------------------------------------------------------------------------
// hhfs_ctrl
// Controller: sequences one input beat through evaluation, name flush and
// end-of-buffer results.
// ----------------------------------------------------------------------------
module hhfs_ctrl import hhfs_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_stall_o,
  input  dp_stat_t stat_i,
  output ctl_cmd_t cmd_o
);

  typedef enum logic [5:0] {
    ST_IDLE     = 6'b000001,
    ST_EVAL     = 6'b000010,
    ST_NAME_RD  = 6'b000100,
    ST_NAME_OUT = 6'b001000,
    ST_FIN_END  = 6'b010000,
    ST_FIN_DONE = 6'b100000
  } state_e;

  state_e state_q, state_d;

  assign in_stall_o = (state_q != ST_IDLE);

  always_comb begin
    state_d            = state_q;
    cmd_o.take         = 1'b0;
    cmd_o.apply        = 1'b0;
    cmd_o.rd_load      = 1'b0;
    cmd_o.rd_adv       = 1'b0;
    cmd_o.out_load     = 1'b0;
    cmd_o.out_kind     = KIND_END;
    cmd_o.out_run_last = 1'b0;
    cmd_o.buf_clear    = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.take = 1'b1;
          state_d    = ST_EVAL;
        end
      end
      ST_EVAL: begin
        if (stat_i.emit_end || stat_i.emit_value) begin
          if (stat_i.out_free) begin
            cmd_o.apply        = 1'b1;
            cmd_o.out_load     = 1'b1;
            cmd_o.out_kind     = stat_i.emit_end ? KIND_END : KIND_VALUE;
            cmd_o.out_run_last = !stat_i.last;
            state_d            = stat_i.last ? ST_FIN_END : ST_IDLE;
          end
        end else if (stat_i.flush) begin
          cmd_o.apply = 1'b1;
          state_d     = ST_NAME_RD;
        end else begin
          cmd_o.apply = 1'b1;
          state_d     = stat_i.last ? ST_FIN_END : ST_IDLE;
        end
      end
      ST_NAME_RD: begin
        cmd_o.rd_load = 1'b1;
        state_d       = ST_NAME_OUT;
      end
      ST_NAME_OUT: begin
        if (stat_i.out_free) begin
          cmd_o.out_load     = 1'b1;
          cmd_o.out_kind     = KIND_NAME;
          cmd_o.out_run_last = stat_i.flush_last && !stat_i.last;
          cmd_o.rd_adv       = 1'b1;
          if (stat_i.flush_last) begin
            state_d = stat_i.last ? ST_FIN_END : ST_IDLE;
          end else begin
            state_d = ST_NAME_RD;
          end
        end
      end
      ST_FIN_END: begin
        if (!stat_i.in_value) begin
          state_d = ST_FIN_DONE;
        end else if (stat_i.out_free) begin
          cmd_o.out_load = 1'b1;
          cmd_o.out_kind = KIND_END;
          state_d        = ST_FIN_DONE;
        end
      end
      ST_FIN_DONE: begin
        if (stat_i.out_free) begin
          cmd_o.out_load     = 1'b1;
          cmd_o.out_kind     = KIND_DONE;
          cmd_o.out_run_last = 1'b1;
          cmd_o.buf_clear    = 1'b1;
          state_d            = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

[src/http_header_field_splitter_unit.sv]
// ----------------------------------------------------------------------------
// http_header_field_splitter_unit
// Splits a raw header block into name bytes, value bytes and header-end and
// buffer-done beats.
// ----------------------------------------------------------------------------
// One input byte is handled at a time: each byte is accepted, then evaluated;
// a colon that ends a name then reads and outputs each name byte up to the
// trimmed length (registered name store read, then output load), and the
// final byte of a buffer then gives the header-end beat, if a value is open,
// and the done beat. Output stall holds the block in the step that loads the
// output; a single output register lets the next byte be accepted while the last result is still waiting.
module http_header_field_splitter_unit import hhfs_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [7:0]         byte_in_i,
  input  logic               last_byte_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [1:0]         kind_o,
  output logic [7:0]         data_byte_o,
  output logic [TOTAL_W-1:0] header_total_o,
  output logic               run_last_o
);

  ctl_cmd_t cmd;
  dp_stat_t stat;

  hhfs_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  hhfs_dp u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .stat_o         (stat),
    .byte_in_i      (byte_in_i),
    .last_byte_i    (last_byte_i),
    .out_stall_i    (out_stall_i),
    .out_valid_o    (out_valid_o),
    .kind_o         (kind_o),
    .data_byte_o    (data_byte_o),
    .header_total_o (header_total_o),
    .run_last_o     (run_last_o)
  );

endmodule

[bench/tb_top.sv]
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for http_header_field_splitter_unit. It drives
// directed header blocks and then random buffers of header, bare, empty
// and noise lines. Both sides take random gaps and output stall. The
// output side holds off for a long stretch once. Every output beat is
// scored against an in-bench model of the splitter.
// ----------------------------------------------------------------------------
module tb_top;
  import hhfs_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 4000000;
  localparam int unsigned RAND_BYTES  = 355;
  localparam int unsigned HOLD_CYCLES = 400;

  typedef struct packed {
    kind_e              kind;
    logic [7:0]         data;
    logic [TOTAL_W-1:0] total;
    logic               run_last;
  } beat_t;

  class splitter_scoreboard;
    beat_t              due_beats[$];
    logic [7:0]         name_buf[NAME_MAX];
    logic [LEN_W-1:0]   stored_len;
    logic [LEN_W-1:0]   trim_len;
    bit                 in_val;
    bit                 val_started;
    bit                 saw_cr;
    logic [TOTAL_W-1:0] hdr_count;
    int unsigned        errors;

    function new();
      clear_line();
      saw_cr    = 1'b0;
      hdr_count = '0;
      errors    = 0;
    endfunction

    function void clear_line();
      stored_len  = '0;
      trim_len    = '0;
      in_val      = 1'b0;
      val_started = 1'b0;
    endfunction

    function void push(kind_e k, logic [7:0] d, logic [TOTAL_W-1:0] t);
      beat_t e;
      e.kind     = k;
      e.data     = d;
      e.total    = t;
      e.run_last = 1'b0;
      due_beats.push_back(e);
    endfunction

    // accepted input beat: append the beats it causes
    function void take_byte(logic [7:0] b, logic fin);
      int unsigned size_at_entry;
      size_at_entry = due_beats.size();
      if (saw_cr && b == CH_LF) begin
        saw_cr = 1'b0;
      end else if (b == CH_CR || b == CH_LF) begin
        if (in_val) push(KIND_END, 8'h00, '0);
        clear_line();
        saw_cr = (b == CH_CR);
      end else begin
        saw_cr = 1'b0;
        if (in_val) begin
          if (val_started || (b != CH_SPACE && b != CH_TAB)) begin
            val_started = 1'b1;
            push(KIND_VALUE, b, '0);
          end
        end else if (b == CH_COLON) begin
          if (hdr_count != TOTAL_MAX) hdr_count++;
          for (int i = 0; i < int'(trim_len); i++) push(KIND_NAME, name_buf[i], '0);
          in_val      = 1'b1;
          val_started = 1'b0;
        end else begin
          if (stored_len < NAME_MAX) begin
            name_buf[stored_len] = b;
            stored_len++;
          end
          // trailing blanks keep the old length: trim first, cut after
          if (b != CH_SPACE && b != CH_TAB) trim_len = stored_len;
        end
      end
      if (fin) begin
        if (in_val) push(KIND_END, 8'h00, '0);
        push(KIND_DONE, 8'h00, hdr_count);
        clear_line();
        saw_cr    = 1'b0;
        hdr_count = '0;
      end
      if (due_beats.size() > size_at_entry) due_beats[due_beats.size() - 1].run_last = 1'b1;
    endfunction

    function void check_beat(beat_t got);
      beat_t want;
      if (due_beats.size() == 0) begin
        $display("%0t: unexpected beat kind=%0d data=%02h total=%0d last=%0b",
                 $time, got.kind, got.data, got.total, got.run_last);
        errors++;
      end else begin
        want = due_beats.pop_front();
        if (got !== want) begin
          $display("%0t: expected kind=%0d data=%02h total=%0d last=%0b",
                   $time, want.kind, want.data, want.total, want.run_last);
          $display("%0t: actual   kind=%0d data=%02h total=%0d last=%0b",
                   $time, got.kind, got.data, got.total, got.run_last);
          errors++;
        end
      end
    endfunction
  endclass

  logic               clk_i;
  logic               rst_ni;
  logic               in_valid_i;
  logic               in_stall_o;
  logic [7:0]         byte_in_i;
  logic               last_byte_i;
  logic               out_valid_o;
  logic               out_stall_i;
  logic [1:0]         kind_o;
  logic [7:0]         data_byte_o;
  logic [TOTAL_W-1:0] header_total_o;
  logic               run_last_o;

  splitter_scoreboard sb;
  bit                 tx_calm;
  bit                 hold_req;
  int unsigned        bytes_sent;

  http_header_field_splitter_unit dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .byte_in_i      (byte_in_i),
    .last_byte_i    (last_byte_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .kind_o         (kind_o),
    .data_byte_o    (data_byte_o),
    .header_total_o (header_total_o),
    .run_last_o     (run_last_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  initial begin : watchdog
    int unsigned cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycles++;
    end
    $display("tb: failure");
    $finish;
  end

  // output side: random stall per beat, one long hold-off on request
  initial begin : sink
    beat_t       got;
    int unsigned wait_left;
    int unsigned hold_left;
    bit          calm;
    bit          hold_taken;
    wait_left   = 0;
    hold_left   = 0;
    calm        = 1'b0;
    hold_taken  = 1'b0;
    out_stall_i = 1'b0;
    forever begin
      @(posedge clk_i);
      if (out_valid_o && !out_stall_i) begin
        got.kind     = kind_e'(kind_o);
        got.data     = data_byte_o;
        got.total    = header_total_o;
        got.run_last = run_last_o;
        sb.check_beat(got);
        if ($urandom_range(0, 31) == 0) calm = !calm;
        wait_left = calm ? 0 : $urandom_range(0, 14);
      end else if (out_valid_o && wait_left > 0) begin
        wait_left--;
      end
      @(negedge clk_i);
      if (hold_req && !hold_taken) begin
        hold_left  = HOLD_CYCLES;
        hold_taken = 1'b1;
      end
      if (hold_left > 0) hold_left--;
      out_stall_i <= (hold_left > 0) || (wait_left > 0);
    end
  end

  task automatic send_byte(input logic [7:0] b, input logic fin);
    int unsigned gap;
    gap = tx_calm ? 0 : $urandom_range(0, 14);
    repeat (gap) begin
      @(negedge clk_i);
      in_valid_i <= 1'b0;
    end
    @(negedge clk_i);
    in_valid_i  <= 1'b1;
    byte_in_i   <= b;
    last_byte_i <= fin;
    do @(posedge clk_i); while (in_stall_o);
    sb.take_byte(b, fin);
    bytes_sent++;
  endtask

  task automatic send_text(input string s, input bit fin);
    for (int i = 0; i < s.len(); i++) send_byte(s[i], fin && (i == s.len() - 1));
  endtask

  // printable name or value byte, with blanks and raw bytes mixed in
  function automatic logic [7:0] text_byte(bit for_value);
    int unsigned r;
    logic [7:0]  c;
    r = $urandom_range(0, 15);
    case (r)
      0:       c = CH_SPACE;
      1:       c = CH_TAB;
      2:       c = for_value ? CH_COLON : 8'h2D;
      3, 4, 5: begin
        c = 8'($urandom_range(0, 255));
        if (c == CH_CR || c == CH_LF || (!for_value && c == CH_COLON)) c = 8'h2D;
      end
      default: c = 8'("a" + $urandom_range(0, 25));
    endcase
    return c;
  endfunction

  initial begin : stimulus
    logic [7:0]  line_q[$];
    int unsigned n_lines;
    int unsigned sel;
    int unsigned len;
    int unsigned rand_start;
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    byte_in_i   = '0;
    last_byte_i = 1'b0;
    tx_calm     = 1'b0;
    hold_req    = 1'b0;
    bytes_sent  = 0;
    sb = new();
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // trimmed name, skipped blanks, colon in value, CRLF; empty name with
    // 0xFF value, LF then CR; bare line dropped at the buffer end
    send_text("Ab \t:\t v:\015\n:\377\n\015", 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte("y", 1'b1);
    // open header closed by the last byte
    send_text("k:z", 1'b1);
    // LF swallowed after CR even on the last byte
    send_text("\015\n", 1'b1);

    rand_start = bytes_sent;
    while (bytes_sent - rand_start < RAND_BYTES) begin
      tx_calm = ($urandom_range(0, 4) == 0);
      line_q.delete();
      n_lines = $urandom_range(1, 4);
      for (int l = 0; l < int'(n_lines); l++) begin
        sel = $urandom_range(0, 99);
        if (sel < 8) begin
          len = $urandom_range(1, 6);
          repeat (len) line_q.push_back(8'($urandom_range(0, 255)));
        end else if (sel >= 16) begin
          len = ($urandom_range(0, 9) == 0) ? $urandom_range(30, 40) : $urandom_range(0, 6);
          repeat (len) line_q.push_back(text_byte(1'b0));
          if (sel >= 26) begin
            line_q.push_back(CH_COLON);
            repeat ($urandom_range(0, 2)) line_q.push_back($urandom_range(0, 1) ? CH_SPACE : CH_TAB);
            repeat ($urandom_range(0, 8)) line_q.push_back(text_byte(1'b1));
          end
        end
        // last line is sometimes left open
        if (l + 1 < int'(n_lines) || $urandom_range(0, 3) != 0) begin
          case ($urandom_range(0, 5))
            0:       line_q.push_back(CH_LF);
            1:       line_q.push_back(CH_CR);
            2: begin
              line_q.push_back(CH_LF);
              line_q.push_back(CH_CR);
            end
            default: begin
              line_q.push_back(CH_CR);
              line_q.push_back(CH_LF);
            end
          endcase
        end
      end
      if (line_q.size() == 0) line_q.push_back(CH_LF);
      foreach (line_q[i]) send_byte(line_q[i], i == line_q.size() - 1);
      if (!hold_req && bytes_sent - rand_start >= 100) hold_req = 1'b1;
    end

    @(negedge clk_i);
    in_valid_i <= 1'b0;

    while (sb.due_beats.size() != 0) @(posedge clk_i);
    repeat (100) @(posedge clk_i);
    if (sb.errors == 0) $display("tb: success");
    else $display("tb: failure");
    $finish;
  end

endmodule
